// ===== src/rc4tw_pkg.sv =====
// Shared types and constants for the two-direction RC4 keystream engine.
package rc4tw_pkg;

  // Permutation box geometry
  localparam int unsigned BOX_DEPTH = 256;
  localparam int unsigned BOX_AW    = 8;
  localparam logic [BOX_AW-1:0] BOX_LAST = BOX_AW'(BOX_DEPTH - 1);

  // Operation codes carried in the input tuser
  localparam logic OP_REKEY = 1'b0;
  localparam logic OP_CRYPT = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_KEY_LO  = 2'd0,
    CFG_KEY_HI  = 2'd1,
    CFG_KEY_LEN = 2'd2
  } cfg_idx_e;

  // Controller states, one-hot
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_INIT  = 10'b00_0000_0010,
    S_KS_RD = 10'b00_0000_0100,
    S_KS_J  = 10'b00_0000_1000,
    S_KS_WN = 10'b00_0001_0000,
    S_KS_WJ = 10'b00_0010_0000,
    S_CR_J  = 10'b00_0100_0000,
    S_CR_WI = 10'b00_1000_0000,
    S_CR_WJ = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // capture the input transaction
    logic init_wr;   // identity fill of both boxes
    logic ks_rd;     // schedule: read S[n]
    logic ks_j;      // schedule: update j, read S[j]
    logic ks_wn;     // schedule: write S[n]
    logic ks_wj;     // schedule: write S[j], advance n
    logic cr_j;      // crypt: update j, read S[j]
    logic cr_wi;     // crypt: write S[i], read S[t]
    logic cr_wj;     // crypt: write S[j], form the output byte
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_crypt;  // incoming transaction is a crypt
    logic len_zero;  // configured key length is zero
    logic keyed;     // boxes hold a valid permutation
    logic n_last;    // box counter at its final entry
    logic out_free;  // output register can take a result
  } status_t;

endpackage

// ===== src/rc4tw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rc4tw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rc4tw_ctrl.sv =====
// Sequencer for key schedule and per-byte crypt steps.
module rc4tw_ctrl
  import rc4tw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (!status_i.in_crypt) begin
            state_d = status_i.len_zero ? S_DONE : S_INIT;
          end else begin
            state_d = status_i.keyed ? S_CR_J : S_DONE;
          end
        end
      end
      S_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (status_i.n_last) begin
          state_d = S_KS_RD;
        end
      end
      S_KS_RD: begin
        cmd_o.ks_rd = 1'b1;
        state_d     = S_KS_J;
      end
      S_KS_J: begin
        cmd_o.ks_j = 1'b1;
        state_d    = S_KS_WN;
      end
      S_KS_WN: begin
        cmd_o.ks_wn = 1'b1;
        state_d     = S_KS_WJ;
      end
      S_KS_WJ: begin
        cmd_o.ks_wj = 1'b1;
        state_d     = status_i.n_last ? S_DONE : S_KS_RD;
      end
      S_CR_J: begin
        cmd_o.cr_j = 1'b1;
        state_d    = S_CR_WI;
      end
      S_CR_WI: begin
        cmd_o.cr_wi = 1'b1;
        state_d     = S_CR_WJ;
      end
      S_CR_WJ: begin
        cmd_o.cr_wj = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Crypt on an unkeyed engine goes straight to the result
  a_bypass_direct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && status_i.in_crypt && !status_i.keyed) |=> (state_q == S_DONE))
    else $error("bypass crypt did not go straight to result");

  // Schedule ends after the last box entry
  a_sched_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_KS_WJ && status_i.n_last) |=> (state_q == S_DONE))
    else $error("key schedule did not finish on last entry");

  // A result is only loaded on the way back to idle
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (state_q == S_IDLE))
    else $error("result load not followed by idle");

endmodule

// ===== src/rc4tw_dpath.sv =====
// Key registers, index state, box memories and output register.
module rc4tw_dpath
  import rc4tw_pkg::*;
#(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  // input transaction fields
  input  logic        in_op_i,
  input  logic        in_dir_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_cend_i,
  // control
  input  cmd_t        cmd_i,
  output status_t     status_o,
  // result
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_data_o,
  output logic        out_dir_o,
  output logic        out_cend_o,
  output logic        out_rekey_o
);

  localparam int unsigned LEN_W  = $clog2(KEY_BYTES + 1);
  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // Configuration registers
  logic [63:0] key_lo_q, key_hi_q;
  logic [4:0]  key_len_q;

  // Engine state
  logic              keyed_q;
  logic [1:0][7:0]   i_q, j_q;
  logic [BOX_AW-1:0] n_q;
  logic [KIDX_W-1:0] kpos_q;
  logic [7:0]        ksj_q, sn_q;

  // Transaction and crypt working registers
  logic       crypt_q, dir_q, cend_q;
  logic [7:0] res_q, ci_q, cj_q, si_q, sj_q;
  logic       hit_i_q, hit_j_q;

  // Output register
  logic       out_valid_q, out_dir_q, out_cend_q, out_rekey_q;
  logic [7:0] out_data_q;

  // Box memory buses
  logic [BOX_AW-1:0] raddr, waddr;
  logic [7:0]        wdata, rd0, rd1, rd_data;
  logic              we0, we1;

  // Derived values
  logic [15:0][7:0]          key_all;
  logic [KEY_BYTES-1:0][7:0] key_arr;
  logic [7:0]                key_byte;
  logic [LEN_W-1:0]          len_sat, kpos_inc;
  logic [7:0]                i_next_in, ks_j_next, cr_j_next, t_next, keystream;

  assign key_all  = {key_hi_q, key_lo_q};
  assign key_arr  = key_all[KEY_BYTES-1:0];
  assign key_byte = key_arr[kpos_q];

  // Lengths above the key capacity saturate
  always_comb begin
    if (key_len_q > 5'(KEY_BYTES)) begin
      len_sat = LEN_W'(KEY_BYTES);
    end else begin
      len_sat = key_len_q[LEN_W-1:0];
    end
  end

  assign kpos_inc  = LEN_W'(kpos_q) + LEN_W'(1);
  assign rd_data   = (crypt_q && dir_q) ? rd1 : rd0;
  assign i_next_in = 8'(i_q[in_dir_i] + 8'd1);
  assign ks_j_next = 8'(ksj_q + rd_data + key_byte);
  assign cr_j_next = 8'(j_q[dir_q] + rd_data);
  assign t_next    = 8'(si_q + rd_data);

  // S[t] read overlapped the swap: forward the swapped values
  always_comb begin
    if (hit_j_q) begin
      keystream = si_q;
    end else if (hit_i_q) begin
      keystream = sj_q;
    end else begin
      keystream = rd_data;
    end
  end

  // Memory address and write selection
  always_comb begin
    raddr = '0;
    waddr = '0;
    wdata = '0;
    we0   = 1'b0;
    we1   = 1'b0;
    priority if (cmd_i.accept) begin
      raddr = i_next_in;
    end else if (cmd_i.init_wr) begin
      waddr = n_q;
      wdata = n_q;
      we0   = 1'b1;
      we1   = 1'b1;
    end else if (cmd_i.ks_rd) begin
      raddr = n_q;
    end else if (cmd_i.ks_j) begin
      raddr = ks_j_next;
    end else if (cmd_i.ks_wn) begin
      waddr = n_q;
      wdata = rd_data;
      we0   = 1'b1;
      we1   = 1'b1;
    end else if (cmd_i.ks_wj) begin
      waddr = ksj_q;
      wdata = sn_q;
      we0   = 1'b1;
      we1   = 1'b1;
    end else if (cmd_i.cr_j) begin
      raddr = cr_j_next;
    end else if (cmd_i.cr_wi) begin
      raddr = t_next;
      waddr = ci_q;
      wdata = rd_data;
      we0   = !dir_q;
      we1   = dir_q;
    end else if (cmd_i.cr_wj) begin
      waddr = cj_q;
      wdata = si_q;
      we0   = !dir_q;
      we1   = dir_q;
    end else begin
      raddr = '0;
    end
  end

  // One box per direction, both written during a rekey
  rc4tw_ram #(.WIDTH(8), .DEPTH(BOX_DEPTH)) u_box0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd0)
  );

  rc4tw_ram #(.WIDTH(8), .DEPTH(BOX_DEPTH)) u_box1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rd1)
  );

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_KEY_LO:  key_lo_q  <= cfg_wdata_i;
        CFG_KEY_HI:  key_hi_q  <= cfg_wdata_i;
        CFG_KEY_LEN: key_len_q <= cfg_wdata_i[4:0];
        default:     key_len_q <= key_len_q;
      endcase
    end
  end

  // Engine control state: keyed flag, indices, schedule counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyed_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      kpos_q  <= '0;
      ksj_q   <= '0;
    end else begin
      if (cmd_i.accept && (in_op_i == OP_REKEY)) begin
        keyed_q <= (key_len_q != '0);
        i_q     <= '0;
        j_q     <= '0;
        n_q     <= '0;
        kpos_q  <= '0;
        ksj_q   <= '0;
      end
      if (cmd_i.init_wr) begin
        n_q <= n_q + BOX_AW'(1);
      end
      if (cmd_i.ks_j) begin
        ksj_q <= ks_j_next;
      end
      if (cmd_i.ks_wj) begin
        n_q <= n_q + BOX_AW'(1);
        if (kpos_inc >= len_sat) begin
          kpos_q <= '0;
        end else begin
          kpos_q <= KIDX_W'(kpos_inc);
        end
      end
      if (cmd_i.cr_wj) begin
        i_q[dir_q] <= ci_q;
        j_q[dir_q] <= cj_q;
      end
    end
  end

  // Transaction capture and crypt working values
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      crypt_q <= in_op_i;
      dir_q   <= in_dir_i;
      cend_q  <= in_cend_i;
      res_q   <= in_data_i;
      ci_q    <= i_next_in;
    end
    if (cmd_i.ks_j) begin
      sn_q <= rd_data;
    end
    if (cmd_i.cr_j) begin
      si_q <= rd_data;
      cj_q <= cr_j_next;
    end
    if (cmd_i.cr_wi) begin
      sj_q    <= rd_data;
      hit_i_q <= (t_next == ci_q);
      hit_j_q <= (t_next == cj_q);
    end
    if (cmd_i.cr_wj) begin
      res_q <= res_q ^ keystream;
    end
  end

  // Output register: holds one result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q  <= crypt_q ? res_q : 8'd0;
      out_dir_q   <= crypt_q & dir_q;
      out_cend_q  <= crypt_q & cend_q;
      out_rekey_q <= !crypt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_dir_o   = out_dir_q;
  assign out_cend_o  = out_cend_q;
  assign out_rekey_o = out_rekey_q;

  assign status_o.in_crypt = (in_op_i == OP_CRYPT);
  assign status_o.len_zero = (key_len_q == '0);
  assign status_o.keyed    = keyed_q;
  assign status_o.n_last   = (n_q == BOX_LAST);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Crypt swaps touch only the chosen direction's box
  a_one_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.cr_wi || cmd_i.cr_wj) |-> $onehot({we1, we0}))
    else $error("crypt write reached both boxes");

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending one");

  // Indices move only on a keyed crypt or a rekey
  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cmd_i.cr_wj && !cmd_i.accept) |=> ($stable(i_q) && $stable(j_q)))
    else $error("index state changed outside crypt or rekey");

endmodule

// ===== src/rc4_stream_cipher_two_way_unit.sv =====
// Top level of the two-direction RC4 keystream engine.
//
//  Channel  Dir  Handshake           Payload
//  s_axis   in   tvalid/tready       tdata: data_in; tuser: operation, direction; tlast
//  m_axis   out  tvalid/tready       tdata: data_out; tuser: out_direction, rekey_done; tlast
//  cfg      in   cfg_we_i (no wait)  cfg_addr_i index, cfg_wdata_i data
//
//  Crypt with a keyed engine: one byte at a time, as the dependent reads on the box
//  memory's one read port run in order (S[i], S[j], write S[i] with S[t] read, write S[j]).
//  Crypt before a keyed rekey, and a rekey with zero key length, go straight to the result.
//  Rekey: identity fill, then 256 schedule rounds (read S[n], read S[j], write S[n], write S[j]).
//  Reset clears the key registers, indices and keyed flag; box contents stay unknown.
//  A finished result waits in the output register while the next transaction is taken.
module rc4_stream_cipher_two_way_unit
  import rc4tw_pkg::*;
#(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
  input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] direction
  input  logic        s_axis_tlast,   // chunk_end
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_out
  output logic [1:0]  m_axis_tuser,   // [0] out_direction, [1] rekey_done
  output logic        m_axis_tlast    // out_chunk_end
);

  cmd_t    cmd;
  status_t status;

  rc4tw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rc4tw_dpath #(.KEY_BYTES(KEY_BYTES)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_op_i     (s_axis_tuser[0]),
    .in_dir_i    (s_axis_tuser[1]),
    .in_data_i   (s_axis_tdata),
    .in_cend_i   (s_axis_tlast),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_dir_o   (m_axis_tuser[0]),
    .out_cend_o  (m_axis_tlast),
    .out_rekey_o (m_axis_tuser[1])
  );

endmodule

// ===== test/rc4_stream_cipher_two_way_unit_test.sv =====
// Self-checking testbench for the two-direction RC4 keystream engine.
`timescale 1ns / 1ps

module rc4_stream_cipher_two_way_unit_test;
  import rc4tw_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned MAX_REPORTS  = 20;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;   // no register behind this index

  // One output transaction as the block should present it
  typedef struct packed {
    logic [7:0] data;
    logic       dir;
    logic       cend;
    logic       rekey;
  } cipher_out_t;

  // Keystream predictor plus store of bytes still owed by the block
  class rc4_scoreboard;
    bit [7:0]    sbox [2][256];
    bit [7:0]    pos_i [2];
    bit [7:0]    pos_j [2];
    bit          is_keyed = 1'b0;
    logic [63:0] key_lo = '0;
    logic [63:0] key_hi = '0;
    logic [4:0]  key_len = '0;
    cipher_out_t owed_bytes [$];
    int          errors = 0;
    int          n_rekey = 0;
    int          n_cipher = 0;
    int          n_plain = 0;
    int          n_checked = 0;

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_KEY_LO:  key_lo = val;
        CFG_KEY_HI:  key_hi = val;
        CFG_KEY_LEN: key_len = val[4:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] key_byte(int k);
      return (k < 8) ? key_lo[k*8 +: 8] : key_hi[(k-8)*8 +: 8];
    endfunction

    // Standard schedule into box 0, then mirrored into box 1
    function void run_key_schedule(int len);
      bit [7:0] j;
      bit [7:0] t;
      int       kpos;
      j = 8'd0;
      kpos = 0;
      for (int n = 0; n < 256; n++) sbox[0][n] = 8'(n);
      for (int n = 0; n < 256; n++) begin
        j = j + sbox[0][n] + key_byte(kpos);
        t = sbox[0][n];
        sbox[0][n] = sbox[0][j];
        sbox[0][j] = t;
        kpos++;
        if (kpos >= len) kpos = 0;
      end
      for (int n = 0; n < 256; n++) sbox[1][n] = sbox[0][n];
    endfunction

    function void note_input(logic op, logic dir, logic [7:0] data, logic cend);
      cipher_out_t res;
      int          len;
      bit [7:0]    i;
      bit [7:0]    j;
      bit [7:0]    t;
      if (op == OP_REKEY) begin
        len = (key_len > 5'd16) ? 16 : int'(key_len);
        if (len > 0) run_key_schedule(len);
        is_keyed = (len > 0);
        pos_i[0] = 8'd0;
        pos_i[1] = 8'd0;
        pos_j[0] = 8'd0;
        pos_j[1] = 8'd0;
        res = '{data: 8'd0, dir: 1'b0, cend: 1'b0, rekey: 1'b1};
        n_rekey++;
      end else begin
        if (is_keyed) begin
          i = pos_i[dir] + 8'd1;
          j = pos_j[dir] + sbox[dir][i];
          t = sbox[dir][i];
          sbox[dir][i] = sbox[dir][j];
          sbox[dir][j] = t;
          t = sbox[dir][i] + sbox[dir][j];
          data = data ^ sbox[dir][t];
          pos_i[dir] = i;
          pos_j[dir] = j;
          n_cipher++;
        end else begin
          n_plain++;
        end
        res = '{data: data, dir: dir, cend: cend, rekey: 1'b0};
      end
      owed_bytes.push_back(res);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_output(logic [7:0] data, logic dir, logic cend, logic rekey);
      cipher_out_t want;
      if (owed_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected output, expected none, actual data %0h dir %0b rekey %0b",
                   $time, data, dir, rekey);
        return;
      end
      want = owed_bytes.pop_front();
      n_checked++;
      cmp("data_out", want.data, data);
      cmp("out_direction", 8'(want.dir), 8'(dir));
      cmp("out_chunk_end", 8'(want.cend), 8'(cend));
      cmp("rekey_done", 8'(want.rekey), 8'(rekey));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  rc4_scoreboard sb = new;
  int src_run = 0;
  int snk_run = 0;
  int items_sent = 0;

  rc4_stream_cipher_two_way_unit #(.KEY_BYTES(16)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Clock and reset
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Random wait before a transaction, with occasional back-to-back runs
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) run_left = $urandom_range(20, 80);
    return $urandom_range(0, 16);
  endfunction

  // Input side: valid stays high between back-to-back transactions
  task automatic send_item(input logic op, input logic dir, input logic [7:0] data,
                           input logic cend);
    int gap;
    gap = draw_wait(src_run);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {dir, op};
    s_axis_tdata  <= data;
    s_axis_tlast  <= cend;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(op, dir, data, cend);
    items_sent++;
  endtask

  task automatic send_crypt(input logic dir, input logic [7:0] data, input logic cend);
    send_item(OP_CRYPT, dir, data, cend);
  endtask

  task automatic send_rekey();
    send_item(OP_REKEY, 1'(($urandom)), 8'($urandom), 1'($urandom));
  endtask

  // Stop the stream and wait until every owed byte has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.owed_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Register writes leave the enable high; cfg_close drops it after a batch
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic cfg_close();
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_key_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [4:0] rand_key_len();
    case ($urandom_range(0, 9))
      0:       return 5'd0;
      1:       return 5'd1;
      2:       return 5'd16;
      3:       return 5'($urandom_range(17, 31));
      default: return 5'($urandom_range(1, 16));
    endcase
  endfunction

  // Output side: random back-pressure, every transaction checked
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_wait(snk_run);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_output(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int burst_len;
    int random_sent;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Crypt before any rekey passes straight through
    send_crypt(1'b0, 8'h00, 1'b0);
    send_crypt(1'b1, 8'hFF, 1'b1);
    send_crypt(1'b0, 8'hA5, 1'b1);
    // Rekey with the reset key length of zero, still plain afterwards
    send_rekey();
    send_crypt(1'b1, 8'h5A, 1'b0);
    drain();

    // Short key "Key", interleaved directions
    cfg_write(CFG_KEY_LO, 64'h0000_0000_0079_654B);
    cfg_write(CFG_KEY_HI, 64'h0);
    cfg_write(CFG_KEY_LEN, 64'd3);
    cfg_close();
    send_rekey();
    send_crypt(1'b0, 8'h50, 1'b0);
    send_crypt(1'b0, 8'h6C, 1'b0);
    send_crypt(1'b1, 8'h00, 1'b0);
    send_crypt(1'b0, 8'h61, 1'b0);
    send_crypt(1'b1, 8'h00, 1'b1);
    drain();

    // Full-length key of all ones
    cfg_write(CFG_KEY_LO, '1);
    cfg_write(CFG_KEY_HI, '1);
    cfg_write(CFG_KEY_LEN, 64'd16);
    cfg_close();
    send_rekey();
    send_crypt(1'b0, 8'hFF, 1'b1);
    send_crypt(1'b1, 8'h00, 1'b0);
    drain();

    // Length above the parameter saturates; stray index is ignored
    cfg_write(CFG_KEY_LO, 64'h0123_4567_89AB_CDEF);
    cfg_write(CFG_KEY_HI, 64'hFEDC_BA98_7654_3210);
    cfg_write(CFG_KEY_LEN, 64'd31);
    cfg_write(CFG_UNUSED, '1);
    cfg_close();
    send_rekey();
    send_crypt(1'b1, 8'h3C, 1'b0);
    send_crypt(1'b0, 8'hC3, 1'b1);
    drain();

    // Single key byte
    cfg_write(CFG_KEY_LEN, 64'd1);
    cfg_close();
    send_rekey();
    send_crypt(1'b0, 8'h80, 1'b0);
    drain();

    // Zero length after a keyed rekey drops back to plain
    cfg_write(CFG_KEY_LEN, 64'd0);
    cfg_close();
    send_rekey();
    send_crypt(1'b1, 8'h01, 1'b1);
    send_crypt(1'b0, 8'hFE, 1'b0);
    drain();

    // Random phases: new settings, usually a rekey, then a burst of bytes
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_KEY_LO, rand_key_word());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_KEY_HI, rand_key_word());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_KEY_LEN, 64'(rand_key_len()));
      if ($urandom_range(0, 9) == 0) cfg_write(CFG_UNUSED, {$urandom, $urandom});
      cfg_close();
      // most phases start clean; the rest run on stale state
      if ($urandom_range(0, 6) != 0) begin
        send_rekey();
        random_sent++;
      end
      burst_len = $urandom_range(8, 60);
      for (int n = 0; n < burst_len; n++) begin
        if ($urandom_range(0, 32) == 0) send_rekey();
        else send_crypt(1'($urandom), 8'($urandom), 1'($urandom));
        random_sent++;
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Sent %0d transactions: %0d rekeys, %0d keyed bytes, %0d plain bytes",
             items_sent, sb.n_rekey, sb.n_cipher, sb.n_plain);
    $display("Checked %0d outputs, %0d mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0 && sb.owed_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rc4tw_pkg.sv
src/rc4tw_ram.sv
src/rc4tw_ctrl.sv
src/rc4tw_dpath.sv
src/rc4_stream_cipher_two_way_unit.sv
test/rc4_stream_cipher_two_way_unit_test.sv
